FILE: design/eased_value_animator_unit_macros.svh
// assertion macros for the eased value animator
// expects clk and arst_n in the scope of each use
`ifndef EASED_VALUE_ANIMATOR_UNIT_MACROS_SVH
`define EASED_VALUE_ANIMATOR_UNIT_MACROS_SVH

// same-cycle implication
`define EVA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/eva_pkg.sv
// shared types, codes and fixed-point constants for the eased value animator
// no dependencies
package eva_pkg;

	// fixed-point format: progress and eased value are unsigned Q1.FB
	localparam int FB = 16;
	localparam int ONE_I = 1 << FB;
	localparam int P_W = FB + 1;
	localparam int DUR_W = 24;
	localparam int CNT_W = $clog2(FB + 1);
	localparam int P11_W = FB + 4;
	localparam int SD_W = FB + 7;
	localparam int M_W = FB + 3;
	localparam int OPA_W = 34;
	localparam int OPB_W = M_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int SH_NEAR = FB + 4;
	localparam int SH_LAST = FB + 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [P_W-1:0] ONE = P_W'(ONE_I);
	localparam logic signed [OPB_W-1:0] ONE_B = OPB_W'(ONE_I);
	localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(ONE_I / 2);
	localparam logic signed [PROD_W-1:0] HALF_NEAR = PROD_W'(1) <<< (SH_NEAR - 1);
	localparam logic signed [PROD_W-1:0] HALF_LAST = PROD_W'(1) <<< (SH_LAST - 1);

	// bounce segment limits on 11p and offsets
	localparam logic [P11_W-1:0] LIM_A = P11_W'(4 * ONE_I);
	localparam logic [P11_W-1:0] LIM_B = P11_W'(8 * ONE_I);
	localparam logic [P11_W-1:0] LIM_C = P11_W'(10 * ONE_I);
	localparam logic signed [SD_W-1:0] CTR_B = SD_W'(6 * ONE_I);
	localparam logic signed [SD_W-1:0] CTR_C = SD_W'(9 * ONE_I);
	localparam logic signed [SD_W-1:0] CTR_D = SD_W'(21 * ONE_I);
	localparam logic [P_W-1:0] OFS_B = P_W'((3 * ONE_I) / 4);
	localparam logic [P_W-1:0] OFS_C = P_W'((15 * ONE_I) / 16);
	localparam logic [P_W-1:0] OFS_D = P_W'((63 * ONE_I) / 64);

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	// unused code, ignored by the block
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	// curve codes
	localparam logic [1:0] CURVE_CUBIC_OUT = 2'd0;
	localparam logic [1:0] CURVE_QUINT_IN  = 2'd1;
	localparam logic [1:0] CURVE_QUINT_OUT = 2'd2;
	localparam logic [1:0] CURVE_BOUNCE    = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_VALUE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd4;

	// bounce segment codes
	localparam logic [1:0] SEG_A = 2'd0;
	localparam logic [1:0] SEG_B = 2'd1;
	localparam logic [1:0] SEG_C = 2'd2;
	localparam logic [1:0] SEG_D = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_MUL,
		ST_RND,
		ST_EMIT
	} eva_state_t;

	typedef enum logic [1:0] {
		PH_CURVE,
		PH_BOUNCE,
		PH_LERP
	} eva_phase_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] frame_time_ms;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               done_res;
	} res_item_t;

endpackage

FILE: design/eased_value_animator_unit.sv
// eased value animator top level: sequencer, restoring divider, shared multiplier
// depends on eva_pkg and eased_value_animator_unit_macros.svh
`include "eased_value_animator_unit_macros.svh"

// A start command arms the animation (or, when disabled or with zero duration,
// returns end_value at once), a tick returns the eased value for its time stamp
// and a stop ends a running animation with the last value. One command is taken
// at a time: a tick inside the animation passes through the accept in the idle
// state, FB steps of the restoring divider for the progress, a setup state, 1 to 3
// easing products and the final interpolation, each a multiply and a rounding
// state on one registered multiplier, and the emit state. A tick before the start
// stamp skips the divider. A stalled result output, while an earlier result still
// waits in the output register, holds the block in the emit state.
// A result may wait in the output register while the next command is taken.
module eased_value_animator_unit import eva_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_item_t            cmd_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_item_t            res_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	// configuration and animation state
	logic signed [31:0]        start_value_q, end_value_q, cur_val_q;
	logic [DUR_W-1:0]          dur_q;
	logic [1:0]                curve_q;
	logic                      enable_q, running_q;
	logic [31:0]               stamp_q;

	// sequencer and datapath registers
	eva_state_t                st_q, st_d;
	eva_phase_t                phase_q;
	logic [DUR_W-1:0]          rem_q;
	logic [FB-1:0]             quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [P_W-1:0]            p_q, base_q;
	logic [1:0]                seg_q;
	logic signed [OPA_W-1:0]   op_a_q;
	logic signed [OPB_W-1:0]   op_b_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [31:0]        pend_val_q;
	logic                      pend_done_q;
	logic                      res_valid_q;
	res_item_t                 res_item_q;

	logic                      cmd_acc, emit_go;
	logic [31:0]               elapsed;
	logic                      late;

	// divider step
	logic [DUR_W:0]            div_t;
	logic                      div_ge;
	logic [DUR_W-1:0]          rem_d;
	logic [FB-1:0]             quo_d;

	// easing setup
	logic [P_W-1:0]            q_val, base_val;
	logic [P11_W-1:0]          p11;
	logic signed [SD_W-1:0]    p11s, sd;
	logic [SD_W-1:0]           sd_abs;
	logic [1:0]                seg_d;
	logic [M_W-1:0]            m_val;

	// rounding after the multiplier
	logic signed [PROD_W-1:0]  sum_q, sum_near, sum_last, lerp_f;
	logic [P_W-1:0]            qm, rb, ofs, e_curve, e_val;
	logic [P_W:0]              eb_raw;
	logic [CNT_W-1:0]          last_step;
	logic signed [OPA_W-1:0]   diff;

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign elapsed = cmd_item.frame_time_ms - stamp_q;
	assign late = !elapsed[31] && (elapsed >= {{(32-DUR_W){1'b0}}, dur_q});

	// restoring division of elapsed << FB by the duration
	assign div_t  = {rem_q, 1'b0};
	assign div_ge = div_t >= {1'b0, dur_q};
	assign rem_d  = div_ge ? DUR_W'(div_t - {1'b0, dur_q}) : div_t[DUR_W-1:0];
	assign quo_d  = {quo_q[FB-2:0], div_ge};

	// curve base and bounce segment
	assign q_val    = ONE - p_q;
	assign base_val = (curve_q == CURVE_QUINT_IN) ? p_q : q_val;
	assign p11      = (P11_W'(p_q) << 3) + (P11_W'(p_q) << 1) + P11_W'(p_q);
	assign p11s     = signed'(SD_W'(p11));
	always_comb begin
		if (p11 < LIM_A) begin
			seg_d = SEG_A;
			sd = p11s;
		end else if (p11 < LIM_B) begin
			seg_d = SEG_B;
			sd = p11s - CTR_B;
		end else if (p11 < LIM_C) begin
			seg_d = SEG_C;
			sd = p11s - CTR_C;
		end else begin
			seg_d = SEG_D;
			sd = (p11s <<< 1) - CTR_D;
		end
	end
	assign sd_abs = sd[SD_W-1] ? SD_W'(-sd) : SD_W'(sd);
	assign m_val  = sd_abs[M_W-1:0];

	// rounding of the registered product
	assign sum_q    = prod_q + HALF_Q;
	assign sum_near = prod_q + HALF_NEAR;
	assign sum_last = prod_q + HALF_LAST;
	assign lerp_f   = sum_q >>> FB;
	assign qm       = sum_q[FB +: P_W];
	assign rb       = (seg_q == SEG_D) ? sum_last[SH_LAST +: P_W] : sum_near[SH_NEAR +: P_W];
	always_comb begin
		case (seg_q)
			SEG_B:   ofs = OFS_B;
			SEG_C:   ofs = OFS_C;
			SEG_D:   ofs = OFS_D;
			default: ofs = '0;
		endcase
	end
	assign eb_raw    = {1'b0, rb} + {1'b0, ofs};
	assign e_curve   = (curve_q == CURVE_QUINT_IN) ? qm : ONE - qm;
	assign last_step = (curve_q == CURVE_CUBIC_OUT) ? CNT_W'(1) : CNT_W'(2);
	always_comb begin
		if (phase_q == PH_BOUNCE) begin
			e_val = (eb_raw > {1'b0, ONE}) ? ONE : eb_raw[P_W-1:0];
		end else begin
			e_val = (e_curve > ONE) ? ONE : e_curve;
		end
	end
	assign diff = OPA_W'(end_value_q) - OPA_W'(start_value_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd_item.cmd)
						CMD_START: begin
							if (!enable_q || dur_q == '0) st_d = ST_EMIT;
						end
						CMD_TICK: begin
							if (running_q) begin
								if (elapsed[31]) st_d = ST_SETUP;
								else if (late) st_d = ST_EMIT;
								else st_d = ST_DIV;
							end
						end
						CMD_STOP: begin
							if (running_q) st_d = ST_EMIT;
						end
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(FB - 1)) st_d = ST_SETUP;
			end
			ST_SETUP: st_d = ST_MUL;
			ST_MUL:   st_d = ST_RND;
			ST_RND: begin
				st_d = (phase_q == PH_LERP) ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (emit_go) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		cmd_stall = (st_q != ST_IDLE);
		cfg_ready = 1'b1;
		emit_go   = (st_q == ST_EMIT) && (!res_valid_q || !res_stall);
		res_valid = res_valid_q;
		res_item  = res_item_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			running_q     <= 1'b0;
			stamp_q       <= '0;
			cur_val_q     <= '0;
			res_valid_q   <= 1'b0;
			start_value_q <= '0;
			end_value_q   <= '0;
			dur_q         <= '0;
			curve_q       <= CURVE_CUBIC_OUT;
			enable_q      <= 1'b1;
		end else begin
			st_q <= st_d;
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_START_VALUE: start_value_q <= signed'(cfg_data);
					CFG_END_VALUE:   end_value_q   <= signed'(cfg_data);
					CFG_DURATION:    dur_q         <= cfg_data[DUR_W-1:0];
					CFG_CURVE:       curve_q       <= cfg_data[1:0];
					CFG_ENABLE:      enable_q      <= cfg_data[0];
					default: ;
				endcase
			end
			// command side effects on the animation state
			if (cmd_acc) begin
				case (cmd_item.cmd)
					CMD_START: begin
						if (!enable_q || dur_q == '0) begin
							running_q <= 1'b0;
						end else begin
							running_q <= 1'b1;
							stamp_q   <= cmd_item.frame_time_ms;
						end
					end
					CMD_TICK: begin
						if (running_q && late) running_q <= 1'b0;
					end
					CMD_STOP: running_q <= 1'b0;
					default: ;
				endcase
			end
			// output register
			if (emit_go) begin
				res_valid_q <= 1'b1;
				cur_val_q   <= pend_val_q;
			end else if (res_stall == 1'b0) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_item_q.value    <= pend_val_q;
			res_item_q.done_res <= pend_done_q;
		end
		unique case (st_q)
			ST_IDLE: begin
				rem_q <= elapsed[DUR_W-1:0];
				quo_q <= '0;
				cnt_q <= '0;
				p_q   <= '0;
				if (cmd_item.cmd == CMD_STOP) begin
					pend_val_q <= cur_val_q;
				end else begin
					pend_val_q <= end_value_q;
				end
				pend_done_q <= 1'b1;
			end
			ST_DIV: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				cnt_q <= cnt_q + CNT_W'(1);
				p_q   <= {1'b0, quo_d};
			end
			ST_SETUP: begin
				cnt_q <= '0;
				if (curve_q == CURVE_BOUNCE) begin
					phase_q <= PH_BOUNCE;
					seg_q   <= seg_d;
					op_a_q  <= signed'(OPA_W'(m_val));
					op_b_q  <= signed'(OPB_W'(m_val));
				end else begin
					phase_q <= PH_CURVE;
					base_q  <= base_val;
					op_a_q  <= signed'(OPA_W'(base_val));
					op_b_q  <= signed'(OPB_W'(base_val));
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(op_a_q) * PROD_W'(op_b_q);
			end
			ST_RND: begin
				if (phase_q == PH_LERP) begin
					pend_val_q  <= start_value_q + signed'(lerp_f[31:0]);
					pend_done_q <= 1'b0;
				end else if (phase_q == PH_BOUNCE || cnt_q == last_step) begin
					phase_q <= PH_LERP;
					op_a_q  <= diff;
					op_b_q  <= signed'(OPB_W'(e_val));
				end else begin
					cnt_q  <= cnt_q + CNT_W'(1);
					op_a_q <= signed'(OPA_W'(qm));
					if (cnt_q + CNT_W'(1) == last_step) begin
						op_b_q <= signed'(OPB_W'(base_q));
					end else begin
						op_b_q <= signed'(OPB_W'(qm));
					end
				end
			end
			ST_EMIT: ;
			default: ;
		endcase
	end

	// checks
	`EVA_ASSERT_NOW(a_div_rem_below, st_q == ST_DIV, rem_q < dur_q, "divider remainder out of range")
	`EVA_ASSERT_NOW(a_div_running, st_q == ST_DIV, running_q, "division without a running animation")
	`EVA_ASSERT_NOW(a_ease_bounded, (st_q == ST_MUL) && (phase_q == PH_LERP), op_b_q <= ONE_B, "eased value above one")
	`EVA_ASSERT_NEXT(a_done_stops, emit_go && pend_done_q, !running_q, "final result left animation running")

endmodule

FILE: verif/eva_checker.sv
// checker for the eased value animator: watches command, result and register channels,
// predicts each result and compares it with what the block returns
// depends on eva_pkg
`timescale 1ns / 100ps

module eva_checker import eva_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 cmd_stall,
	input  cmd_item_t            cmd_item,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_item_t            res_item,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam longint unsigned UNIT = 64'd1 << FB;

	// register copies
	logic signed [31:0] from_val, to_val;
	logic [DUR_W-1:0]   span_ms;
	logic [1:0]         curve_sel;
	logic               anim_en;

	// animation state
	logic [31:0]        stamp;
	logic               active;
	logic signed [31:0] last_val;

	res_item_t          exp_results[$];

	function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
		return (a * b + (UNIT >> 1)) >> FB;
	endfunction

	function automatic longint unsigned sq_round(longint d, int extra);
		longint unsigned m;
		int sh;
		m = (d < 0) ? longint'(-d) : longint'(d);
		sh = FB + extra;
		return (m * m + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// easing curve on progress p, clamped to one
	function automatic longint unsigned eased(longint unsigned p);
		longint unsigned q, e, t;
		longint p11, s1;
		q = UNIT - p;
		p11 = longint'(p) * 11;
		s1 = longint'(UNIT);
		case (curve_sel)
			CURVE_CUBIC_OUT: begin
				e = UNIT - fx_mul(fx_mul(q, q), q);
			end
			CURVE_QUINT_IN: begin
				t = fx_mul(p, p);
				e = fx_mul(fx_mul(t, t), p);
			end
			CURVE_QUINT_OUT: begin
				t = fx_mul(q, q);
				e = UNIT - fx_mul(fx_mul(t, t), q);
			end
			default: begin
				if (p11 < 4 * s1)
					e = sq_round(p11, 4);
				else if (p11 < 8 * s1)
					e = sq_round(p11 - 6 * s1, 4) + (3 * UNIT) / 4;
				else if (p11 < 10 * s1)
					e = sq_round(p11 - 9 * s1, 4) + (15 * UNIT) / 16;
				else
					e = sq_round(2 * p11 - 21 * s1, 6) + (63 * UNIT) / 64;
			end
		endcase
		return (e > UNIT) ? UNIT : e;
	endfunction

	// linear blend between the two end values
	function automatic logic signed [31:0] blend(longint unsigned e);
		longint a, diff, x, f;
		a = longint'(from_val);
		diff = longint'(to_val) - a;
		x = diff * longint'(e) + longint'(UNIT >> 1);
		if (x >= 0)
			f = x >>> FB;
		else
			f = -((-x + longint'(UNIT) - 1) >>> FB);
		return 32'(a + f);
	endfunction

	task automatic push_result(logic signed [31:0] v, logic fin);
		res_item_t r;
		r.value = v;
		r.done_res = fin;
		last_val = v;
		exp_results.push_back(r);
	endtask

	// state update for one accepted command
	task automatic animate(cmd_item_t it);
		logic [31:0] d;
		longint unsigned p;
		case (it.cmd)
			CMD_START: begin
				if (!anim_en || span_ms == 0) begin
					active = 1'b0;
					push_result(to_val, 1'b1);
				end else begin
					stamp = it.frame_time_ms;
					active = 1'b1;
				end
			end
			CMD_TICK: begin
				if (active) begin
					d = it.frame_time_ms - stamp;
					if (d[31]) begin
						push_result(blend(eased(0)), 1'b0);
					end else if (d >= 32'(span_ms)) begin
						active = 1'b0;
						push_result(to_val, 1'b1);
					end else begin
						p = (longint'(d) << FB) / longint'(span_ms);
						push_result(blend(eased(p)), 1'b0);
					end
				end
			end
			CMD_STOP: begin
				if (active) begin
					active = 1'b0;
					push_result(last_val, 1'b1);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			from_val = '0;
			to_val = '0;
			span_ms = '0;
			curve_sel = CURVE_CUBIC_OUT;
			anim_en = 1'b1;
			stamp = '0;
			active = 1'b0;
			last_val = '0;
			exp_results.delete();
			errors = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_VALUE: from_val = cfg_data;
					CFG_END_VALUE:   to_val = cfg_data;
					CFG_DURATION:    span_ms = cfg_data[DUR_W-1:0];
					CFG_CURVE:       curve_sel = cfg_data[1:0];
					CFG_ENABLE:      anim_en = cfg_data[0];
					default: ;
				endcase
			end
			// result transfer against the oldest prediction
			if (res_valid && !res_stall) begin
				if (exp_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: value %0d done %0b",
							res_item.value, res_item.done_res);
				end else begin
					want = exp_results.pop_front();
					if (res_item.value !== want.value || res_item.done_res !== want.done_res) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected value %0d done %0b, got value %0d done %0b",
								want.value, want.done_res, res_item.value, res_item.done_res);
					end
				end
			end
			// command transfer
			if (cmd_valid && !cmd_stall)
				animate(cmd_item);
		end
		pending = exp_results.size();
	end

endmodule

FILE: verif/tb.sv
// testbench top for eased_value_animator_unit: clock, reset, stimulus and verdict
// depends on eva_pkg and eva_checker
`timescale 1ns / 100ps

module tb;
	import eva_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_item_t            cmd_item = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_item_t            res_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_START_VALUE;
	logic [31:0]          cfg_data = '0;
	int                   errors, pending;
	int                   sent = 0;
	logic                 calm = 1'b0;

	eased_value_animator_unit dut (.*);

	eva_checker chk (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// one command transfer, with an occasional gap before it
	task automatic send(logic [1:0] c, logic [31:0] t);
		if (!calm && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= '{cmd: c, frame_time_ms: t};
		do @(posedge clk); while (cmd_stall);
		sent++;
	endtask

	// drain all outstanding results, then let the block settle
	task automatic drain();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(logic [31:0] sv, logic [31:0] ev, logic [31:0] dur,
			logic [1:0] cv, logic en);
		drain();
		write_reg(CFG_START_VALUE, sv);
		write_reg(CFG_END_VALUE, ev);
		write_reg(CFG_DURATION, dur);
		write_reg(CFG_CURVE, cv);
		write_reg(CFG_ENABLE, {31'(0), en});
	endtask

	initial begin
		logic [31:0] t0, dur, lo, hi;
		int n;
		logic [1:0] cv;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle commands, extremes, each curve, special cases
		send(CMD_TICK, 32'd5);
		send(CMD_STOP, 32'd5);
		send(CMD_RSVD, 32'hFFFF_FFFF);
		send(CMD_START, 32'd0);
		setup(32'h8000_0000, 32'h7FFF_FFFF, 1000, CURVE_CUBIC_OUT, 1'b1);
		send(CMD_START, 32'hFFFF_FF00);
		send(CMD_TICK, 32'hFFFF_FF00);
		send(CMD_TICK, 32'hFFFF_FE00);
		send(CMD_TICK, 32'h0000_00E8);
		send(CMD_STOP, 32'd0);
		setup(32'h7FFF_FFFF, 32'h8000_0000, 1000, CURVE_QUINT_IN, 1'b1);
		send(CMD_START, 32'd100);
		send(CMD_TICK, 32'd600);
		send(CMD_TICK, 32'd1099);
		send(CMD_TICK, 32'd1100);
		for (int k = 0; k < 2; k++) begin
			setup(-32'sd500, 32'd500, 32'h00FF_FFFF, CURVE_QUINT_OUT + 2'(k), 1'b1);
			send(CMD_START, 32'd0);
			send(CMD_TICK, 32'h0055_5555);
			send(CMD_TICK, 32'h00E8_BA2E);
			send(CMD_TICK, 32'h00FF_FFFE);
		end
		setup(32'd1, 32'd9, 32'd0, CURVE_BOUNCE, 1'b1);
		send(CMD_START, 32'd7);
		setup(32'd1, 32'd9, 32'd50, CURVE_BOUNCE, 1'b0);
		send(CMD_START, 32'd7);

		// random animations
		while (sent < 1550) begin
			if (sent > 1350)
				calm = 1'b1;
			case ($urandom_range(0, 3))
				0: begin lo = $urandom; hi = $urandom; end
				1: begin lo = $urandom_range(0, 2000) - 1000; hi = $urandom_range(0, 2000) - 1000; end
				2: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
				default: begin lo = $urandom_range(0, 100); hi = lo; end
			endcase
			case ($urandom_range(0, 9))
				0: dur = 0;
				1: dur = $urandom_range(1, 32'h00FF_FFFF);
				2: dur = 32'h00FF_FFFF;
				default: dur = $urandom_range(1, 400);
			endcase
			cv = 2'($urandom_range(0, 3));
			setup($urandom_range(0, 1) ? lo : hi, $urandom_range(0, 1) ? hi : lo,
				$urandom_range(0, 15) == 0 ? ($urandom | 32'h0100_0000) : dur,
				cv, $urandom_range(0, 9) != 0);
			if (dur > 400 && $urandom_range(0, 1)) dur = 400;
			t0 = $urandom;
			send(CMD_START, t0);
			n = $urandom_range(4, 16);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(0, 19))
					0: send(CMD_STOP, $urandom);
					1: send(CMD_RSVD, $urandom);
					2: send(CMD_START, t0);
					3: send(CMD_TICK, $urandom);
					4: send(CMD_TICK, t0 - $urandom_range(1, 100));
					5: send(CMD_TICK, t0 + dur + $urandom_range(0, 3));
					default: send(CMD_TICK, t0 + (dur * (k + 1)) / n - $urandom_range(0, 1));
				endcase
			end
		end

		drain();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
